// ===== rtl/core/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the allocated range table: operation and
// status codes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

	localparam int ART_TABLE_DEPTH  = 16;
	localparam int ART_ADDR_WIDTH   = 32;

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_CHECK      = 2'd2,
		OP_NONE       = 2'd3
	} art_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_BAD  = 2'd3
	} art_status_t;

	// controller -> datapath
	typedef struct packed {
		logic        load_in;
		logic        calc;
		logic        reg_write;
		logic        unreg_clear;
		logic        walk_init;
		logic        walk_step;
		logic        load_out;
		art_status_t code;
	} art_cmd_t;

	// datapath -> controller
	typedef struct packed {
		art_op_t op;
		logic    bad;
		logic    overlap;
		logic    full;
		logic    match;
		logic    hit;
		logic    covered;
	} art_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/allocated_range_table.sv =====
// ----------------------------------------------------------------------------
// allocated_range_table
// Table of non-overlapping inclusive address ranges with register,
// unregister and coverage check requests; one status result per request.
//
//   channel   dir  tdata fields (low bit up)               width
//   s_*       in   op[1:0], base_address, range_length     72 at defaults
//   m_*       out  status[1:0], entries_used               8 at defaults
//
// A register or unregister request passes through decode, execute and finish;
// the result is loaded into the output register and output valid raised as
// the controller returns to idle, where the next request can be taken. A check
// also walks the chain after execute, reusing the single holder compare per step.
// A new request is accepted once the previous one has its result in the
// output register, even if that result is still waiting on m_tready.
// Reset clears all slot valid bits and the entry count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module allocated_range_table
	import art_pkg::*;
#(
	parameter int TABLE_DEPTH   = ART_TABLE_DEPTH,
	parameter int ADDRESS_WIDTH = ART_ADDR_WIDTH,
	localparam int IN_W  = ((2 + 2 * ADDRESS_WIDTH + 7) / 8) * 8,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // op, base_address, range_length
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata    // status, entries_used
);

	art_cmd_t cmd;
	art_sts_t sts;

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	art_dpath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/core/art_dpath.sv =====
// ----------------------------------------------------------------------------
// art_dpath
// Datapath of the range table: request registers, range end computation,
// slot storage with parallel overlap/match/holder compares, chain walk
// pointer, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module art_dpath
	import art_pkg::*;
#(
	parameter int TABLE_DEPTH   = ART_TABLE_DEPTH,
	parameter int ADDRESS_WIDTH = ART_ADDR_WIDTH,
	localparam int IN_W  = ((2 + 2 * ADDRESS_WIDTH + 7) / 8) * 8,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire art_cmd_t         cmd,
	output art_sts_t              sts,
	output logic      [OUT_W-1:0] m_tdata
);

	localparam int AW    = ADDRESS_WIDTH;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	art_op_t          op_q;
	logic [AW-1:0]    base_q;
	logic [AW-1:0]    len_q;
	logic [AW-1:0]    hi_q;
	logic             bad_q;
	logic [AW-1:0]    cur_q;
	logic [AW-1:0]    start_q [TABLE_DEPTH];
	logic [AW-1:0]    end_q   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] count_q;
	logic [OUT_W-1:0] out_q;

	logic [AW:0]            sum;
	logic [TABLE_DEPTH-1:0] ovl_vec;
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [AW-1:0]          holder_end;
	logic [IDX_W-1:0]       free_idx;

	assign sum = {1'b0, base_q} + {1'b0, len_q} - {{AW{1'b0}}, 1'b1};

	always_comb begin
		holder_end = '0;
		free_idx   = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ovl_vec[i]   = valid_q[i] && (start_q[i] <= hi_q) && (base_q <= end_q[i]);
			match_vec[i] = valid_q[i] && (start_q[i] == base_q) && (end_q[i] == hi_q);
			hit_vec[i]   = valid_q[i] && (start_q[i] <= cur_q) && (cur_q <= end_q[i]);
			// ranges never overlap, so at most one holder contributes
			if (hit_vec[i]) begin
				holder_end = holder_end | end_q[i];
			end
		end
		// lowest free slot wins
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		sts.op      = op_q;
		sts.bad     = bad_q;
		sts.overlap = |ovl_vec;
		sts.full    = &valid_q;
		sts.match   = |match_vec;
		sts.hit     = |hit_vec;
		sts.covered = hi_q <= holder_end;
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= art_op_t'(s_tdata[1:0]);
			base_q <= s_tdata[AW+1:2];
			len_q  <= s_tdata[2*AW+1:AW+2];
		end
		if (cmd.calc) begin
			hi_q  <= sum[AW-1:0];
			bad_q <= (len_q == '0) || sum[AW];
		end
		if (cmd.walk_init) begin
			cur_q <= base_q;
		end else if (cmd.walk_step) begin
			cur_q <= holder_end + {{(AW-1){1'b0}}, 1'b1};
		end
		if (cmd.load_out) begin
			out_q <= OUT_W'({count_q, cmd.code});
		end
	end

	// slot payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.reg_write) begin
			start_q[free_idx] <= base_q;
			end_q[free_idx]   <= hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.reg_write) begin
				valid_q[free_idx] <= 1'b1;
				count_q           <= count_q + CNT_W'(1);
			end else if (cmd.unreg_clear) begin
				valid_q <= valid_q & ~match_vec;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign m_tdata = out_q;

`ifndef SYNTHESIS
	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("entry count out of step with valid slots");

	a_write_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_write |-> (!(&valid_q) && !(|ovl_vec) && !valid_q[free_idx]))
		else $error("slot write without a free, non-overlapping slot");

	a_clear_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unreg_clear |-> $onehot(match_vec))
		else $error("unregister clear without exactly one matching slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/art_ctrl.sv =====
// ----------------------------------------------------------------------------
// art_ctrl
// Controller of the range table: sequences one request through decode,
// execute and chain walk, picks the status code and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module art_ctrl
	import art_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire art_sts_t sts,
	output art_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_WALK,
		S_FINISH
	} state_t;

	state_t      state_q;
	art_status_t code_q;
	logic        m_valid_q;

	art_status_t exec_code;
	logic        exec_walk;
	logic        out_free;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.code  = code_q;
		exec_code = ST_MISS;
		exec_walk = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = s_tvalid;
			end
			S_DECODE: begin
				cmd.calc = 1'b1;
			end
			S_EXEC: begin
				priority if (sts.op == OP_NONE) begin
					exec_code = ST_MISS;
				end else if (sts.bad) begin
					exec_code = ST_BAD;
				end else begin
					unique case (sts.op)
						OP_REGISTER: begin
							priority if (sts.overlap) begin
								exec_code = ST_MISS;
							end else if (sts.full) begin
								exec_code = ST_FULL;
							end else begin
								exec_code     = ST_OK;
								cmd.reg_write = 1'b1;
							end
						end
						OP_UNREGISTER: begin
							if (sts.match) begin
								exec_code       = ST_OK;
								cmd.unreg_clear = 1'b1;
							end
						end
						OP_CHECK: begin
							exec_walk     = 1'b1;
							cmd.walk_init = 1'b1;
						end
						default: begin
							exec_code = ST_MISS;
						end
					endcase
				end
			end
			S_WALK: begin
				cmd.walk_step = sts.hit && !sts.covered;
			end
			S_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			code_q    <= ST_OK;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_walk) begin
						state_q <= S_WALK;
					end else begin
						code_q  <= exec_code;
						state_q <= S_FINISH;
					end
				end
				S_WALK: begin
					// advance along the chain until a gap or the covering entry
					if (!sts.hit || sts.covered) begin
						code_q  <= sts.hit ? ST_OK : ST_MISS;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_DECODE))
		else $error("accepted transfer did not enter decode");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == S_FINISH))
		else $error("output valid raised outside finish");

	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> $past(state_q == S_EXEC || state_q == S_WALK))
		else $error("chain walk entered from wrong state");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the allocated range table. Register, unregister and
// coverage check requests go in over the input stream. A scoreboard keeps its
// own copy of the range table, works out the status and entry count for each
// accepted request and checks every returned result in order. The random part
// runs under several phases of sender idling and receiver stalls. One phase
// holds off the receiver long enough to back up the input.
// ----------------------------------------------------------------------------

module tb;
	import art_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 270;

	typedef logic [ART_ADDR_WIDTH-1:0] addr_t;

	typedef struct packed {
		art_status_t status;
		logic [4:0]  used;
	} outcome_t;

	class range_table_scoreboard;
		addr_t       slot_lo [ART_TABLE_DEPTH];
		addr_t       slot_hi [ART_TABLE_DEPTH];
		bit          slot_on [ART_TABLE_DEPTH];
		outcome_t    outcome_q [$];
		int unsigned mismatches;

		function int unsigned used_slots();
			int unsigned n;
			n = 0;
			foreach (slot_on[i])
				if (slot_on[i])
					n++;
			return n;
		endfunction

		function int find_holder(addr_t a);
			foreach (slot_on[i])
				if (slot_on[i] && slot_lo[i] <= a && a <= slot_hi[i])
					return i;
			return -1;
		endfunction

		// Update the table copy and return the status the block must give.
		function art_status_t apply_request(art_op_t op, addr_t base, addr_t len);
			addr_t hi;
			addr_t cur;
			int    free_idx;
			int    k;
			if (op == OP_NONE)
				return ST_MISS;
			// ~base is the room left above base
			if (len == 0 || addr_t'(len - 1) > ~base)
				return ST_BAD;
			hi = base + len - 1;
			case (op)
			OP_REGISTER: begin
				free_idx = -1;
				foreach (slot_on[i]) begin
					if (slot_on[i]) begin
						if (slot_lo[i] <= hi && base <= slot_hi[i])
							return ST_MISS;
					end else if (free_idx < 0) begin
						free_idx = i;
					end
				end
				if (free_idx < 0)
					return ST_FULL;
				slot_lo[free_idx] = base;
				slot_hi[free_idx] = hi;
				slot_on[free_idx] = 1'b1;
				return ST_OK;
			end
			OP_UNREGISTER: begin
				k = find_holder(base);
				if (k < 0 || slot_lo[k] != base || slot_hi[k] != hi)
					return ST_MISS;
				slot_on[k] = 1'b0;
				return ST_OK;
			end
			default: begin
				// walk the chain; each step lands on a different entry
				cur = base;
				for (int step = 0; step < ART_TABLE_DEPTH; step++) begin
					k = find_holder(cur);
					if (k < 0)
						return ST_MISS;
					if (hi <= slot_hi[k])
						return ST_OK;
					cur = slot_hi[k] + 1;
				end
				return ST_MISS;
			end
			endcase
		endfunction

		function void note_request(art_op_t op, addr_t base, addr_t len);
			outcome_t o;
			o.status = apply_request(op, base, len);
			o.used   = 5'(used_slots());
			outcome_q.push_back(o);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(logic [7:0] data);
			outcome_t    want;
			art_status_t got_status;
			logic [4:0]  got_used;
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("result %h with no request pending", data));
				return;
			end
			want       = outcome_q.pop_front();
			got_status = art_status_t'(data[1:0]);
			got_used   = data[6:2];
			if (got_status !== want.status)
				report_mismatch($sformatf("status %0d, want %s",
					data[1:0], want.status.name()));
			if (got_used !== want.used)
				report_mismatch($sformatf("entries_used %0d, want %0d",
					got_used, want.used));
		endtask
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;   // op[1:0], base_address[33:2], range_length[65:34]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // status[1:0], entries_used[6:2]

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_off       = 1'b0;
	int unsigned quiet_cycles   = 0;

	range_table_scoreboard table_sb = new;

	allocated_range_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// check results and watch for a hung block
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			table_sb.check_result(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Call at a falling edge; returns at the falling edge after the transfer.
	task send_request(input art_op_t op, input addr_t base, input addr_t len);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, len, base, op};
		do
			@(posedge clk);
		while (!s_tready);
		table_sb.note_request(op, base, len);
		@(negedge clk);
	endtask

	task random_request();
		int unsigned pick;
		int          live [$];
		int          k;
		addr_t       base;
		addr_t       len;
		art_op_t     op;
		foreach (table_sb.slot_on[i])
			if (table_sb.slot_on[i])
				live.push_back(i);
		pick = $urandom_range(99);
		// mostly a small window near zero, some near the top address
		base = ($urandom_range(6) == 0) ? 32'hFFFF_FC00 : 32'h0;
		base = base + $urandom_range(63) * 16;
		if ($urandom_range(3) == 0)
			base = base + $urandom_range(15);
		len = $urandom_range(1) ? $urandom_range(1, 4) * 16 : $urandom_range(1, 64);
		k = (live.size() > 0) ? live[$urandom_range(live.size() - 1)] : -1;
		if (pick < 10) begin
			op   = art_op_t'($urandom_range(3));
			base = $urandom;
			len  = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
		end else if (pick < 45) begin
			op = OP_REGISTER;
		end else if (pick < 70) begin
			op = OP_UNREGISTER;
			if (k >= 0 && $urandom_range(3) != 0) begin
				base = table_sb.slot_lo[k];
				len  = table_sb.slot_hi[k] - base + 1;
				if ($urandom_range(4) == 0)
					len = len + 1;
			end
		end else begin
			op = OP_CHECK;
			if (k >= 0 && $urandom_range(3) != 0) begin
				base = table_sb.slot_lo[k] +
					$urandom_range(table_sb.slot_hi[k] - table_sb.slot_lo[k]);
				len  = table_sb.slot_hi[k] - base + 1 + $urandom_range(96);
			end
		end
		send_request(op, base, len);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_NONE, 32'h100, 32'h10);
		send_request(OP_REGISTER, 32'h100, 32'h0);
		send_request(OP_UNREGISTER, 32'h100, 32'h0);
		send_request(OP_CHECK, 32'h100, 32'h0);
		send_request(OP_REGISTER, 32'hFFFF_FFF0, 32'h20);
		send_request(OP_REGISTER, 32'h0, 32'hFFFF_FFFF);
		send_request(OP_CHECK, 32'hFFFF_FFFF, 32'h1);
		send_request(OP_REGISTER, 32'hFFFF_FFFF, 32'h1);
		send_request(OP_CHECK, 32'h10, 32'hFFFF_FFF0);
		send_request(OP_REGISTER, 32'h5, 32'h1);
		send_request(OP_UNREGISTER, 32'h0, 32'h2);
		send_request(OP_UNREGISTER, 32'h0, 32'hFFFF_FFFF);
		send_request(OP_UNREGISTER, 32'hFFFF_FFFF, 32'h1);
		// fill the table with one contiguous chain, then overflow it
		for (int i = 0; i < ART_TABLE_DEPTH; i++)
			send_request(OP_REGISTER, i * 256, 32'h100);
		send_request(OP_REGISTER, 32'h1_0000, 32'h1);
		send_request(OP_REGISTER, 32'h80, 32'h1);
		send_request(OP_CHECK, 32'h0, 32'h1000);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			1: begin
				send_idle_pct  = 78;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 78;
			end
			3: begin
				send_idle_pct  = 21;
				recv_stall_pct = 21;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			endcase
			if (ph == 4) begin
				// stall the output while requests keep coming
				fork
					begin
						@(posedge clk);
						hold_off = 1'b1;
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			repeat (PHASE_ITEMS) random_request();
		end
		s_tvalid <= 1'b0;

		while (table_sb.outcome_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (table_sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
